// ===== design/b36_pkg.sv =====
// ---------------------------------------------------------------------------
// b36_pkg
// Shared types, constants and helpers of the base-36 text converter.
// ---------------------------------------------------------------------------
package b36_pkg;

	localparam int DIGIT_SLOTS = 13;
	localparam int DIGIT_W     = 6;
	localparam int CNT_W       = 4;
	localparam int CHAR_W      = 7;
	localparam int VALUE_W     = 64;
	localparam int CHUNK_W     = 16;
	localparam int CHUNKS      = VALUE_W / CHUNK_W;
	localparam int CHUNK_IDX_W = $clog2(CHUNKS);

	// Partial dividend of one step: remainder digit above one chunk.
	localparam int PART_W      = DIGIT_W + CHUNK_W;
	// floor(x / 9) == (x * RECIP_9) >> RECIP_SHIFT for every x below 2^20.
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 24;
	localparam logic [RECIP_W-1:0] RECIP_9 = 21'd1864136;

	localparam logic [CHAR_W-1:0] MINUS_CODE = 7'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic load_sign;
		logic load_digit;
	} ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] code;
		if (d < 6'd10) begin
			code = 7'd48 + {1'b0, d};
		end else if (d < 6'd36) begin
			code = 7'd87 + {1'b0, d};
		end else begin
			code = 7'd122;
		end
		return code;
	endfunction

endpackage

// ===== design/b36_div_unit.sv =====
// ---------------------------------------------------------------------------
// b36_div_unit
// One long-division step by 36: the running remainder and one 16-bit chunk
// of the dividend give one 16-bit quotient chunk and the new remainder.
// ---------------------------------------------------------------------------
module b36_div_unit
	import b36_pkg::*;
(
	input  logic [DIGIT_W-1:0] rem_in,
	input  logic [CHUNK_W-1:0] chunk_in,
	output logic [CHUNK_W-1:0] quo_out,
	output logic [DIGIT_W-1:0] rem_out
);

	logic [PART_W-1:0]           part;
	logic [PART_W-3:0]           part_div4;
	logic [PART_W-2+RECIP_W-1:0] prod;
	logic [CHUNK_W-1:0]          quo;
	logic [PART_W-1:0]           quo_x36;
	logic [PART_W-1:0]           diff;

	// Since rem_in stays below 36 the partial dividend is below 36 * 2^16,
	// so the quotient fits in one chunk. Divide by 4 with a shift, then by 9
	// with an exact reciprocal.
	assign part      = {rem_in, chunk_in};
	assign part_div4 = part[PART_W-1:2];
	assign prod      = part_div4 * RECIP_9;
	assign quo       = prod[RECIP_SHIFT +: CHUNK_W];
	assign quo_x36   = {1'b0, quo, 5'b0} + {4'b0, quo, 2'b0};
	assign diff      = part - quo_x36;

	assign quo_out = quo;
	assign rem_out = diff[DIGIT_W-1:0];

endmodule

// ===== design/int64_to_base36_ascii.sv =====
// ---------------------------------------------------------------------------
// int64_to_base36_ascii
// Converts a signed 64-bit integer to lowercase base-36 ASCII text.
// ---------------------------------------------------------------------------
// One beat on s_* carries a signed 64-bit value; the block answers with its
// base-36 text on m_*, one ASCII character per beat, most significant first,
// '-' ahead of negative values, tlast on the final character. s_tready is
// high only while the block is idle. After the input beat, each digit is
// found by the shared divide-by-36 unit, which works through the magnitude
// 16 bits a cycle; the characters then leave at one per cycle when m_tready
// is high. A value gives up to 13 digits and a sign. The next input beat is
// taken once the last character is in the output register.
module int64_to_base36_ascii
	import b36_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value (signed)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] char_code, [7] zero
	output logic        m_tlast    // last_char
);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [VALUE_W-1:0]     quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [CHUNK_IDX_W-1:0] chunk_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       idx_q;
	logic                   neg_q;
	logic [DIGIT_W-1:0]     digit_q [DIGIT_SLOTS];

	logic                   m_tvalid_q;
	logic [CHAR_W-1:0]      m_code_q;
	logic                   m_tlast_q;

	logic [CHUNK_W-1:0]     step_quo;
	logic [DIGIT_W-1:0]     step_rem;
	logic [VALUE_W-1:0]     quo_next;
	logic                   last_chunk;
	logic                   digit_done;
	logic                   conv_done;
	logic                   out_free;
	logic                   in_neg;
	logic [VALUE_W-1:0]     in_mag;

	b36_div_unit u_div (
		.rem_in   (rem_q),
		.chunk_in (quo_q[VALUE_W-1 -: CHUNK_W]),
		.quo_out  (step_quo),
		.rem_out  (step_rem)
	);

	assign quo_next   = {quo_q[VALUE_W-CHUNK_W-1:0], step_quo};
	assign last_chunk = (chunk_q == CHUNK_IDX_W'(CHUNKS - 1));
	assign digit_done = last_chunk;
	assign conv_done  = digit_done &&
		((quo_next == '0) || (cnt_q == CNT_W'(DIGIT_SLOTS - 1)));
	assign out_free   = !m_tvalid_q || m_tready;
	assign in_neg     = s_tdata[VALUE_W-1];
	assign in_mag     = in_neg ? (VALUE_W'(0) - s_tdata) : s_tdata;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (conv_done) state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (out_free) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && (idx_q == '0)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ST_IDLE:   ctrl.accept     = s_tvalid;
			ST_DIVIDE: ctrl.step       = 1'b1;
			ST_SIGN:   ctrl.load_sign  = out_free;
			ST_EMIT:   ctrl.load_digit = out_free;
			default:   ctrl = '0;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quo_q   <= '0;
			rem_q   <= '0;
			chunk_q <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.accept) begin
				quo_q   <= in_mag;
				rem_q   <= '0;
				chunk_q <= '0;
				cnt_q   <= '0;
				neg_q   <= in_neg;
			end else if (ctrl.step) begin
				quo_q   <= quo_next;
				chunk_q <= chunk_q + 1'b1;
				if (digit_done) begin
					// The remainder restarts at zero for the next digit.
					rem_q <= '0;
					cnt_q <= cnt_q + 1'b1;
					idx_q <= cnt_q;
				end else begin
					rem_q <= step_rem;
				end
			end else if (ctrl.load_digit && (idx_q != '0)) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	// Digits are written least significant first and read back from the top.
	always_ff @(posedge clk) begin
		if (ctrl.step && digit_done) begin
			digit_q[cnt_q] <= step_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.load_sign || ctrl.load_digit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_sign) begin
			m_code_q  <= MINUS_CODE;
			m_tlast_q <= 1'b0;
		end else if (ctrl.load_digit) begin
			m_code_q  <= digit_to_ascii(digit_q[idx_q]);
			m_tlast_q <= (idx_q == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_code_q};
	assign m_tlast  = m_tlast_q;

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Checks int64_to_base36_ascii against a predictor of its base-36 text.
// Directed values (zero, unit values, digit boundaries, powers of 36 and
// both 64-bit extremes) come first. After them comes a random mix of full
// 64-bit values, small values, values of at most a chosen digit count and
// values next to powers of 36. Both stream sides stall at random. Every
// character beat is compared with the oldest predicted character.
// ---------------------------------------------------------------------------
module testbench;
	import b36_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_VALUES  = 340;
	localparam int STALL_PERCENT  = 19;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 80;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [VALUE_W-1:0] value;
		bit                 drain_first;
	} value_item_t;

	typedef struct {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // [63:0] value (signed)
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [6:0] char_code, [7] zero
	logic        m_tlast;        // last_char

	value_item_t values_to_send[$];
	text_char_t  expected_chars[$];
	logic        value_taken = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatch_count = 0;
	logic        calm;

	int64_to_base36_ascii u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One window of the run has no random stalls on either side.
	assign calm = (cycle_count >= 4000) && (cycle_count < 7000);

	// Appends the characters that one value turns into, sign first.
	function automatic void predict_base36_text(input logic [VALUE_W-1:0] value);
		logic [DIGIT_W-1:0] digits [DIGIT_SLOTS];
		logic [VALUE_W-1:0] quotient;
		int                 count;
		text_char_t         c;
		quotient = value[VALUE_W-1] ? -value : value;
		count = 0;
		do begin
			digits[count] = DIGIT_W'(quotient % 64'd36);
			quotient = quotient / 64'd36;
			count++;
		end while (quotient != 0 && count < DIGIT_SLOTS);
		if (value[VALUE_W-1]) begin
			c.code = MINUS_CODE;
			c.last = 1'b0;
			expected_chars = {expected_chars, c};
		end
		for (int i = count - 1; i >= 0; i--) begin
			if (digits[i] < 10) begin
				c.code = CHAR_W'(48 + digits[i]);
			end else begin
				c.code = CHAR_W'(87 + digits[i]);
			end
			c.last = (i == 0);
			expected_chars = {expected_chars, c};
		end
	endfunction

	function automatic logic [VALUE_W-1:0] power_of_36(input int k);
		logic [VALUE_W-1:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++) begin
			p = p * 64'd36;
		end
		return p;
	endfunction

	function automatic void queue_value(input logic [VALUE_W-1:0] value, input bit drain);
		value_item_t item;
		item.value = value;
		item.drain_first = drain;
		values_to_send = {values_to_send, item};
	endfunction

	function automatic logic [VALUE_W-1:0] random_value();
		logic [VALUE_W-1:0] v;
		int                 k;
		k = $urandom_range(1, 12);
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = 64'($urandom_range(0, 100000));
			2: v = {$urandom, $urandom} % power_of_36(k);
			default: v = power_of_36(k) + 64'($urandom_range(0, 2)) - 64'd1;
		endcase
		if ($urandom_range(0, 1) == 1) begin
			v = -v;
		end
		return v;
	endfunction

	// Input side: a new beat is offered only once the previous one is gone.
	always @(negedge clk) begin : drive_values
		bit load;
		load = 1'b0;
		if (arst_n && (!s_tvalid || value_taken)) begin
			if (values_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PERCENT)) begin
				load = !values_to_send[0].drain_first || expected_chars.size() == 0;
			end
			if (load) begin
				s_tvalid <= 1'b1;
				s_tdata <= values_to_send[0].value;
				values_to_send.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= arst_n && (calm || $urandom_range(0, 99) >= STALL_PERCENT);
	end

	always @(posedge clk) begin : check_text
		text_char_t want;
		cycle_count <= cycle_count + 1;
		value_taken <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			predict_base36_text(s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%t: character beat %h (last %b) with none expected",
						$realtime, m_tdata, m_tlast);
				end
			end else begin
				want = expected_chars.pop_front();
				if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%t: expected char %h last %b, got %h last %b",
							$realtime, {1'b0, want.code}, want.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// Directed values: zero, digit and sign boundaries, powers of 36, extremes.
		queue_value(64'd0, 1'b0);
		queue_value(64'd1, 1'b0);
		queue_value(-64'd1, 1'b0);
		queue_value(64'd9, 1'b0);
		queue_value(64'd10, 1'b0);
		queue_value(64'd35, 1'b0);
		queue_value(-64'd35, 1'b0);
		queue_value(64'd36, 1'b0);
		queue_value(-64'd36, 1'b0);
		queue_value(64'd1295, 1'b0);
		queue_value(64'd1296, 1'b0);
		queue_value(power_of_36(12) - 64'd1, 1'b0);
		queue_value(power_of_36(12), 1'b0);
		queue_value(-power_of_36(12), 1'b0);
		queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		queue_value(64'h8000_0000_0000_0000, 1'b0);
		queue_value(64'h8000_0000_0000_0001, 1'b0);
		queue_value(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		queue_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		queue_value(64'h5555_5555_5555_5555, 1'b0);
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			// Now and then the sender holds back until all text has drained.
			queue_value(random_value(), (i % 60) == 0);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (values_to_send.size() != 0 || s_tvalid || expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_chars.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/b36_pkg.sv
design/b36_div_unit.sv
design/int64_to_base36_ascii.sv
verif/testbench.sv
